// ===== rtl/mbfp_pkg.sv =====
// ============================================================================
// mbfp_pkg - shared definitions for the MSB-first bit field packer
// Command codes, register indexes, configuration struct and default sizes.
// ============================================================================
package mbfp_pkg;

    // Default sizes for the top level parameters
    localparam int MAX_FIELD_BITS_DEF = 64;
    localparam int ADDR_BITS_DEF      = 32;

    // Fixed field widths
    localparam int BIT_COUNT_W = 7;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Input commands
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_ALIGN  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GROWABLE = 2'd1;

    // Configuration seen by the back end
    typedef struct packed {
        logic [CFG_DATA_W-1:0] capacity;
        logic                  growable;
    } t_cfg;

endpackage

// ===== rtl/mbfp_front.sv =====
// ============================================================================
// mbfp_front - bit merging front end
// Merges each accepted item with the pending partial byte, splits off the
// completed bytes for the queue and keeps the remaining bits; an align zero-pads them to a byte.
// ============================================================================
module mbfp_front #(
    parameter int MAX_FIELD_BITS = mbfp_pkg::MAX_FIELD_BITS_DEF,
    parameter int DATA_W         = 64,
    parameter int CNT_W          = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_cmd,
    input  logic [MAX_FIELD_BITS-1:0]          i_field_value,
    input  logic [mbfp_pkg::BIT_COUNT_W-1:0]   i_bit_count,
    input  logic                               i_full,
    output logic                               o_push,
    output logic [DATA_W-1:0]                  o_push_data,
    output logic [CNT_W-1:0]                   o_push_count
);

    localparam int CAT_W = MAX_FIELD_BITS + 7;
    localparam int TOT_W = $clog2(CAT_W + 1);
    localparam int BC_W  = mbfp_pkg::BIT_COUNT_W;

    logic [6:0] r_partial, n_partial;
    logic [2:0] r_pending, n_pending;

    logic                      accept;
    logic [BC_W-1:0]           len;
    logic [MAX_FIELD_BITS-1:0] masked;
    logic [CAT_W-1:0]          cat;
    logic [CAT_W-1:0]          shifted;
    logic [TOT_W-1:0]          total;
    logic [2:0]                res;
    logic [3:0]                pad;
    logic [7:0]                align_byte;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    // Clamp the width and join the pending bits with the new field
    always_comb begin
        len     = (i_bit_count > BC_W'(MAX_FIELD_BITS)) ? BC_W'(MAX_FIELD_BITS) : i_bit_count;
        masked  = i_field_value & ~({MAX_FIELD_BITS{1'b1}} << len);
        cat     = (CAT_W'(r_partial) << len) | CAT_W'(masked);
        total   = TOT_W'(r_pending) + TOT_W'(len);
        res     = total[2:0];
        shifted = cat >> res;
        pad        = 4'd8 - {1'b0, r_pending};
        align_byte = {1'b0, r_partial} << pad;
    end

    // Select what goes to the queue and what stays behind
    always_comb begin
        if (i_cmd == mbfp_pkg::CMD_ALIGN) begin
            o_push_data  = DATA_W'(align_byte);
            o_push_count = (r_pending != 3'd0) ? CNT_W'(1) : CNT_W'(0);
            n_partial    = 7'd0;
            n_pending    = 3'd0;
        end else begin
            o_push_data  = DATA_W'(shifted);
            o_push_count = CNT_W'(total >> 3);
            n_partial    = cat[6:0] & ~(7'h7F << res);
            n_pending    = res;
        end
        o_push = accept && (o_push_count != CNT_W'(0));
    end

    // Partial byte state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= 7'd0;
            r_pending <= 3'd0;
        end else if (accept) begin
            r_partial <= n_partial;
            r_pending <= n_pending;
        end
    end

`ifndef ASSERT_OFF
    // An align always leaves the byte boundary clean
    a_align_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == mbfp_pkg::CMD_ALIGN) |=> (r_pending == 3'd0 && r_partial == 7'd0))
        else $error("align left pending bits");
`endif

endmodule

// ===== rtl/mbfp_queue.sv =====
// ============================================================================
// mbfp_queue - small FIFO between front and back
// Holds groups of completed bytes so both sides can stall on their own.
// ============================================================================
module mbfp_queue #(
    parameter int WIDTH = 68,
    parameter int DEPTH = mbfp_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != CNT_W'(0));
    assign o_data  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("queue underflow");
`endif

endmodule

// ===== rtl/mbfp_back.sv =====
// ============================================================================
// mbfp_back - byte emitter
// Emits queued bytes one a cycle while the output is not stalled, with their
// address, applies the capacity limit, saturates the position and marks the last byte of each item.
// ============================================================================
module mbfp_back #(
    parameter int ADDR_BITS = mbfp_pkg::ADDR_BITS_DEF,
    parameter int DATA_W    = 64,
    parameter int CNT_W     = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mbfp_pkg::t_cfg       i_cfg,
    input  logic                 i_q_valid,
    output logic                 o_q_pop,
    input  logic [DATA_W-1:0]    i_q_data,
    input  logic [CNT_W-1:0]     i_q_count,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_out_byte,
    output logic [ADDR_BITS-1:0] o_byte_address,
    output logic                 o_last
);

    localparam int                 CW      = mbfp_pkg::CFG_DATA_W;
    localparam logic [ADDR_BITS-1:0] POS_MAX = {ADDR_BITS{1'b1}};

    logic [DATA_W-1:0]    r_data;
    logic [CNT_W-1:0]     r_rem;
    logic [ADDR_BITS-1:0] r_pos;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic [ADDR_BITS-1:0] r_out_addr;
    logic                 r_out_last;

    logic                 out_free, busy, drop, step, emit, final_step;
    logic [CNT_W-1:0]     idx;
    logic [7:0]           cur_byte;
    logic [ADDR_BITS-1:0] pos_next;
    logic                 is_last;

    // Byte selection, capacity check and last flag
    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        busy       = (r_rem != CNT_W'(0));
        drop       = !i_cfg.growable && (CW'(r_pos) >= i_cfg.capacity);
        step       = out_free && busy;
        emit       = step && !drop;
        final_step = step && (drop || r_rem == CNT_W'(1));
        o_q_pop    = i_q_valid && (!busy || final_step);
        idx        = r_rem - CNT_W'(1);
        cur_byte   = 8'(r_data >> {idx, 3'b000});
        pos_next   = (r_pos == POS_MAX) ? r_pos : r_pos + ADDR_BITS'(1);
        is_last    = (r_rem == CNT_W'(1)) ||
                     (!i_cfg.growable && (CW'(pos_next) >= i_cfg.capacity));
    end

    // Current group and write position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_pos <= '0;
        end else begin
            if (o_q_pop) begin
                r_rem <= i_q_count;
            end else if (step) begin
                r_rem <= drop ? CNT_W'(0) : r_rem - CNT_W'(1);
            end
            if (emit) begin
                r_pos <= pos_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_data <= i_q_data;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= cur_byte;
            r_out_addr <= r_pos;
            r_out_last <= is_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_byte_address = r_out_addr;
    assign o_last         = r_out_last;

`ifndef ASSERT_OFF
    // Kept bytes advance the position by one until it saturates
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_pos != POS_MAX) |=> (r_pos == $past(r_pos) + ADDR_BITS'(1)))
        else $error("write position did not advance");
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !emit |=> (r_pos == $past(r_pos)))
        else $error("write position moved without a kept byte");
`endif

endmodule

// ===== rtl/msb_first_bit_field_packer.sv =====
// ============================================================================
// msb_first_bit_field_packer - MSB-first bit field packer
// Packs variable-width fields into a byte stream, most significant bit
// first, and emits every completed byte with its address.
// ============================================================================
//
//  Channel   Direction  Handshake                     Payload
//  in        input      i_in_valid / o_in_stall       i_cmd, i_field_value, i_bit_count
//  out       output     o_out_valid / i_out_stall     o_out_byte, o_byte_address, o_last
//  cfg       input      i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
//  The front end takes one item a cycle while the queue has room.
//  The back end emits one byte a cycle while the output is not stalled; an
//  item yields at most 8 bytes, and a run of dropped bytes is skipped at once.
//  New items are taken while bytes of earlier items still wait in the queue.
//  Synchronous active-low reset clears partial byte, position and queue.
//  A stall on the output holds the output register; the queue then fills
//  and stalls the input side.
//
module msb_first_bit_field_packer #(
    parameter int MAX_FIELD_BITS = mbfp_pkg::MAX_FIELD_BITS_DEF,
    parameter int ADDR_BITS      = mbfp_pkg::ADDR_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_cmd,
    input  logic [MAX_FIELD_BITS-1:0]           i_field_value,
    input  logic [mbfp_pkg::BIT_COUNT_W-1:0]    i_bit_count,
    // output bytes
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [7:0]                          o_out_byte,
    output logic [ADDR_BITS-1:0]                o_byte_address,
    output logic                                o_last,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mbfp_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [mbfp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int MAX_BYTES = (MAX_FIELD_BITS + 7) / 8;
    localparam int DATA_W    = MAX_BYTES * 8;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int Q_W       = DATA_W + CNT_W;

    mbfp_pkg::t_cfg r_cfg;

    logic              push, full, pop, q_valid;
    logic [DATA_W-1:0] push_data;
    logic [CNT_W-1:0]  push_count;
    logic [Q_W-1:0]    q_data;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity <= '0;
            r_cfg.growable <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mbfp_pkg::REG_CAPACITY: r_cfg.capacity <= i_cfg_data;
                mbfp_pkg::REG_GROWABLE: r_cfg.growable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    mbfp_front #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS),
        .DATA_W         (DATA_W),
        .CNT_W          (CNT_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_cmd         (i_cmd),
        .i_field_value (i_field_value),
        .i_bit_count   (i_bit_count),
        .i_full        (full),
        .o_push        (push),
        .o_push_data   (push_data),
        .o_push_count  (push_count)
    );

    mbfp_queue #(
        .WIDTH (Q_W),
        .DEPTH (mbfp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_data, push_count}),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    mbfp_back #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_W    (DATA_W),
        .CNT_W     (CNT_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .o_q_pop        (pop),
        .i_q_data       (q_data[Q_W-1:CNT_W]),
        .i_q_count      (q_data[CNT_W-1:0]),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_address (o_byte_address),
        .o_last         (o_last)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top - testbench for the MSB-first bit field packer
// Drives append and align transactions under random input gaps and output
// stalls, predicts every emitted byte with its address and last flag, and
// checks each output transaction in order. Buffer settings are changed
// between phases while the block is idle: growable, fixed with no room,
// fixed with a small headroom, and fixed at full capacity.
// ============================================================================
module tb_top;

    localparam int FIELD_W       = mbfp_pkg::MAX_FIELD_BITS_DEF;
    localparam int ADDR_W        = mbfp_pkg::ADDR_BITS_DEF;
    localparam int BC_W          = mbfp_pkg::BIT_COUNT_W;
    localparam int CI_W          = mbfp_pkg::CFG_INDEX_W;
    localparam int CD_W          = mbfp_pkg::CFG_DATA_W;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 400000;

    // One expected output transaction
    typedef struct packed {
        logic [7:0]        data;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } t_packed_byte;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the packer state, expected byte store
    // ------------------------------------------------------------------------
    class packer_scoreboard;
        logic [31:0]       capacity;
        logic              growable;
        logic [6:0]        partial;
        int                held_bits;
        logic [ADDR_W-1:0] position;
        t_packed_byte      expected_bytes[$];
        t_packed_byte      item_bytes[$];
        int                errors;
        int                bytes_checked;

        function new();
            capacity      = '0;
            growable      = 1'b1;
            partial       = '0;
            held_bits     = 0;
            position      = '0;
            errors        = 0;
            bytes_checked = 0;
        endfunction

        function void configure(logic [CI_W-1:0] index, logic [CD_W-1:0] value);
            if (index == mbfp_pkg::REG_CAPACITY) begin
                capacity = value;
            end else if (index == mbfp_pkg::REG_GROWABLE) begin
                growable = value[0];
            end
        endfunction

        // Shift one bit into the partial byte; a full byte is kept or dropped
        function void shift_in(logic b);
            logic [7:0]   acc;
            t_packed_byte rec;
            acc = {partial, b};
            held_bits++;
            if (held_bits < 8) begin
                partial = acc[6:0];
                return;
            end
            held_bits = 0;
            partial   = '0;
            if (!growable && position >= capacity) begin
                return;
            end
            rec.data = acc;
            rec.addr = position;
            rec.last = 1'b0;
            item_bytes.push_back(rec);
            if (position != {ADDR_W{1'b1}}) begin
                position++;
            end
        endfunction

        // Accepted input transaction: work out the bytes it produces
        function void note_item(logic cmd, logic [FIELD_W-1:0] value,
                                logic [BC_W-1:0] count);
            int width;
            int pad;
            int i;
            item_bytes.delete();
            if (cmd == mbfp_pkg::CMD_APPEND) begin
                width = (count > FIELD_W) ? FIELD_W : int'(count);
                for (i = width; i > 0; i--) begin
                    shift_in(value[i-1]);
                end
            end else if (held_bits > 0) begin
                pad = 8 - held_bits;
                for (i = 0; i < pad; i++) begin
                    shift_in(1'b0);
                end
            end
            if (item_bytes.size() > 0) begin
                item_bytes[item_bytes.size()-1].last = 1'b1;
            end
            foreach (item_bytes[k]) begin
                expected_bytes.push_back(item_bytes[k]);
            end
        endfunction

        // Accepted output transaction against the oldest expectation
        function void check_byte(logic [7:0] data, logic [ADDR_W-1:0] addr, logic last);
            t_packed_byte want;
            if (expected_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected byte %02h at address %08h", $time, data, addr);
                return;
            end
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (data !== want.data) begin
                errors++;
                $display("%0t: out_byte expected %02h, actual %02h", $time, want.data, data);
            end
            if (addr !== want.addr) begin
                errors++;
                $display("%0t: byte_address expected %08h, actual %08h",
                         $time, want.addr, addr);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last expected %0b, actual %0b", $time, want.last, last);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs
    // ------------------------------------------------------------------------
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               i_cmd         = mbfp_pkg::CMD_APPEND;
    logic [FIELD_W-1:0] i_field_value = '0;
    logic [BC_W-1:0]    i_bit_count   = '0;
    logic               i_out_stall   = 1'b0;
    logic               i_cfg_valid   = 1'b0;
    logic [CI_W-1:0]    i_cfg_index   = mbfp_pkg::REG_CAPACITY;
    logic [CD_W-1:0]    i_cfg_data    = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [7:0]         o_out_byte;
    logic [ADDR_W-1:0]  o_byte_address;
    logic               o_last;
    logic               o_cfg_ready;

    packer_scoreboard sb = new();
    int items_sent    = 0;
    int quiet_items   = 0;
    int stall_left    = 0;
    int quiet_cycles  = 0;
    int cycle_count   = 0;

    always #5 i_clk = ~i_clk;

    msb_first_bit_field_packer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_field_value  (i_field_value),
        .i_bit_count    (i_bit_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_address (o_byte_address),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Output monitor and random stall generation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_byte(o_out_byte, o_byte_address, o_last);
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            if (quiet_cycles > 0) begin
                quiet_cycles--;
            end else begin
                case ($urandom_range(0, 99)) inside
                    [0:2]:   quiet_cycles = $urandom_range(30, 120);
                    [3:19]:  stall_left = $urandom_range(1, 3);
                    [20:21]: stall_left = $urandom_range(10, 40);
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------

    // Gap after an input transaction: mostly short, a few long, quiet runs
    function automatic int pick_gap();
        int r;
        if (quiet_items > 0) begin
            quiet_items--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 94) return $urandom_range(4, 10);
        if (r < 97) return $urandom_range(20, 40);
        quiet_items = $urandom_range(15, 40);
        return 0;
    endfunction

    task automatic send_item(input logic cmd, input logic [FIELD_W-1:0] value,
                             input logic [BC_W-1:0] count);
        int gap;
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_field_value <= value;
        i_bit_count   <= count;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(cmd, value, count);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Random transaction: mostly appends of assorted widths, some aligns
    task automatic send_random();
        logic               cmd;
        logic [FIELD_W-1:0] value;
        logic [BC_W-1:0]    count;
        cmd = ($urandom_range(0, 99) < 15) ? mbfp_pkg::CMD_ALIGN : mbfp_pkg::CMD_APPEND;
        case ($urandom_range(0, 19))
            0:       count = '0;
            1:       count = BC_W'(FIELD_W);
            2:       count = BC_W'($urandom_range(FIELD_W + 1, 127));
            3, 4:    count = BC_W'($urandom_range(1, 8));
            default: count = BC_W'($urandom_range(1, FIELD_W));
        endcase
        case ($urandom_range(0, 9))
            0:       value = '1;
            1:       value = '0;
            default: value = {$urandom, $urandom};
        endcase
        send_item(cmd, value, count);
    endtask

    // Hold off the sender until every expected byte has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            if (i == n / 2) begin
                wait_drained();
            end
            send_random();
        end
    endtask

    // Register writes, only with the block idle
    task automatic write_config(input logic [CD_W-1:0] capacity, input logic growable);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= mbfp_pkg::REG_CAPACITY;
        i_cfg_data  <= capacity;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.configure(mbfp_pkg::REG_CAPACITY, capacity);
        i_cfg_index <= mbfp_pkg::REG_GROWABLE;
        i_cfg_data  <= CD_W'(growable);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.configure(mbfp_pkg::REG_GROWABLE, CD_W'(growable));
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset configuration (growable)
        send_item(mbfp_pkg::CMD_APPEND, '1, 7'd0);                      // zero width
        send_item(mbfp_pkg::CMD_ALIGN, '1, 7'd64);                      // nothing held
        send_item(mbfp_pkg::CMD_APPEND, '1, 7'd64);                     // full width ones
        send_item(mbfp_pkg::CMD_APPEND, '0, 7'd64);                     // full width zeros
        send_item(mbfp_pkg::CMD_APPEND, 64'hFFFF_FFFF_FFFF_FFFD, 7'd3); // high bits ignored
        send_item(mbfp_pkg::CMD_ALIGN, 64'h1234_5678_9ABC_DEF0, 7'd5);  // pad five bits
        send_item(mbfp_pkg::CMD_APPEND, 64'h1, 7'd1);
        send_item(mbfp_pkg::CMD_APPEND, 64'h0123_4567_89AB_CDEF, 7'd64);
        send_item(mbfp_pkg::CMD_APPEND, 64'h55, 7'd7);
        send_item(mbfp_pkg::CMD_APPEND, 64'hFEDC_BA98_7654_3210, 7'd127); // width clamped
        send_item(mbfp_pkg::CMD_APPEND, 64'h8000_0000_0000_0001, 7'd65);
        send_item(mbfp_pkg::CMD_APPEND, 64'h7F, 7'd7);
        send_item(mbfp_pkg::CMD_ALIGN, '0, 7'd0);                       // pad one bit
        send_item(mbfp_pkg::CMD_APPEND, 64'hA5, 7'd8);
        send_item(mbfp_pkg::CMD_APPEND, '0, 7'd7);
        send_item(mbfp_pkg::CMD_ALIGN, '1, 7'd127);
        send_item(mbfp_pkg::CMD_APPEND, 64'hC, 7'd4);
        send_item(mbfp_pkg::CMD_APPEND, 64'h3, 7'd4);
        send_item(mbfp_pkg::CMD_APPEND, 64'h2AA, 7'd10);
        send_item(mbfp_pkg::CMD_ALIGN, '0, 7'd64);
        send_item(mbfp_pkg::CMD_ALIGN, '0, 7'd64);                      // second is empty
        run_random(40);

        // Fixed buffer with no room: every byte dropped
        write_config('0, 1'b0);
        run_random(15);

        // Fixed buffer with a little headroom: fills up mid-phase
        write_config(CD_W'(sb.position) + 32'd40, 1'b0);
        run_random(50);

        // Fixed buffer at full capacity
        write_config(32'hFFFF_FFFF, 1'b0);
        run_random(45);

        // Back to growable with an arbitrary stale capacity
        write_config($urandom, 1'b1);
        run_random(50);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d input transactions, %0d output bytes compared", items_sent,
                 sb.bytes_checked);
        $display("tb_top: covered growable, no-room, headroom and full-capacity buffers");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
